// ----- rtl/core/swmc_pkg.sv -----
// ----------------------------------------------------------------------------
// swmc_pkg: shared definitions for the sliding window median cost block
// Defaults, fixed field widths and the sorted cell operation code.
// ----------------------------------------------------------------------------
`default_nettype none

package swmc_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int SAMPLE_PORT_W   = 32;
	localparam int CFG_W           = 9;
	localparam int COST_BITS       = 40;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_REMOVE = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

endpackage

`default_nettype wire

// ----- rtl/core/sliding_window_median_cost.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_cost: sum of absolute deviations from the lower median
// Sliding window kept in arrival order (ring memory) and sorted order (cells).
// ----------------------------------------------------------------------------
// Usage:
//   Samples (sample_value, restart) transfer when sample_valid is high and
//   sample_stall low. restart empties the window before the sample is taken.
//   Once the window holds window_size samples, each sample yields one
//   window_cost, transferred when cost_valid is high and cost_stall low.
//   window_size is written through cfg_valid/cfg_ready while idle; any write
//   empties the window. 0 is taken as 1, values above MAX_WINDOW saturate.
//   A pending cfg_valid holds off samples.
// Sequence:
//   A sample that gives no result is accepted and then inserted.
//   A sample that gives a result is accepted, removes the oldest sample (not
//   for the sample that fills the window) and is inserted; then the sorted cell
//   row is rotated once through its head cell to sum both halves, then the
//   median products and the final sum are registered in turn.
//   One sample is in work at a time; the next is taken while a result waits.
// Reset and stall:
//   Reset empties the window and sets window_size to 1. A stalled result
//   holds in the output register; the block waits there before finishing the
//   next result.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_cost #(
	parameter int MAX_WINDOW  = swmc_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 sample_valid,
	output logic                                sample_stall,
	input  wire  [swmc_pkg::SAMPLE_PORT_W-1:0]  sample_value,
	input  wire                                 restart,
	output logic                                cost_valid,
	input  wire                                 cost_stall,
	output logic [swmc_pkg::COST_BITS-1:0]      window_cost,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [swmc_pkg::CFG_W-1:0]          window_size
);

	localparam int IDX_W  = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int PROD_W = SAMPLE_BITS + CNT_W;
	localparam int CB     = swmc_pkg::COST_BITS;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REMOVE = 6'b000010,
		ST_INSERT = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_MUL    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [SAMPLE_BITS-1:0] ring_q [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] old_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] med_q;
	logic [CNT_W-1:0]       ws_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       pos_q;
	logic [IDX_W-1:0]       scan_q;
	logic [CB-1:0]          lo_sum_q;
	logic [CB-1:0]          hi_sum_q;
	logic [CB-1:0]          lo_prod_q;
	logic [CB-1:0]          hi_prod_q;
	logic [CB-1:0]          cost_q;
	logic                   cost_valid_q;

	logic [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
	swmc_pkg::cell_op_t     cell_op;
	logic [SAMPLE_BITS-1:0] cell_operand;

	logic                   idle;
	logic                   accept;
	logic                   cfg_write;
	logic [SAMPLE_BITS-1:0] new_sample;
	logic [CNT_W-1:0]       cnt_eff;
	logic [IDX_W-1:0]       pos_eff;
	logic [CNT_W-1:0]       lo_n;
	logic [CNT_W-1:0]       hi_n;
	logic [CNT_W-1:0]       scan_cnt;
	logic [CNT_W-1:0]       cfg_size;
	logic                   pos_wrap;
	logic                   out_free;

	assign idle         = (state_q == ST_IDLE);
	assign sample_stall = !idle || cfg_valid;
	assign cfg_ready    = idle;
	assign accept       = sample_valid && idle && !cfg_valid;
	assign cfg_write    = cfg_valid && idle;
	assign cost_valid   = cost_valid_q;
	assign window_cost  = cost_q;
	assign out_free     = !cost_valid_q || !cost_stall;

	assign new_sample = sample_value[SAMPLE_BITS-1:0];
	assign cnt_eff    = restart ? '0 : count_q;
	assign pos_eff    = (restart || {1'b0, pos_q} >= (IDX_W+1)'(ws_q)) ? '0 : pos_q;
	assign pos_wrap   = ((IDX_W+1)'(pos_eff) + (IDX_W+1)'(1)) >= (IDX_W+1)'(ws_q);
	assign lo_n       = CNT_W'(({1'b0, ws_q} + (CNT_W+1)'(1)) >> 1);
	assign hi_n       = ws_q - lo_n;
	assign scan_cnt   = CNT_W'(scan_q);

	always_comb begin
		if (window_size == '0) begin
			cfg_size = CNT_W'(1);
		end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
			cfg_size = CNT_W'(MAX_WINDOW);
		end else begin
			cfg_size = CNT_W'(window_size);
		end
	end

	always_comb begin
		cell_operand = sample_q;
		case (state_q)
			ST_REMOVE: begin
				cell_op      = swmc_pkg::CELL_REMOVE;
				cell_operand = old_q;
			end
			ST_INSERT: cell_op = swmc_pkg::CELL_INSERT;
			ST_SCAN:   cell_op = swmc_pkg::CELL_ROTATE;
			default:   cell_op = swmc_pkg::CELL_HOLD;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			swmc_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.CNT_W(CNT_W),
				.INDEX(gi)
			) u_cell (
				.clk(clk),
				.op(cell_op),
				.count(count_q),
				.operand(cell_operand),
				.left_value(cell_val[(gi + MAX_WINDOW - 1) % MAX_WINDOW]),
				.right_value(cell_val[(gi + 1) % MAX_WINDOW]),
				.value(cell_val[gi])
			);
		end
	endgenerate

	// ring: read-before-write at the slot being replaced
	always_ff @(posedge clk) begin
		if (accept) begin
			old_q          <= ring_q[pos_eff];
			ring_q[pos_eff] <= new_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= new_sample;
		end
		if (state_q == ST_INSERT) begin
			lo_sum_q <= '0;
			hi_sum_q <= '0;
		end else if (state_q == ST_SCAN) begin
			if (scan_cnt < lo_n) begin
				lo_sum_q <= lo_sum_q + CB'(cell_val[0]);
			end else if (scan_cnt < ws_q) begin
				hi_sum_q <= hi_sum_q + CB'(cell_val[0]);
			end
			if (scan_cnt == lo_n - CNT_W'(1)) begin
				med_q <= cell_val[0];
			end
		end
		if (state_q == ST_MUL) begin
			lo_prod_q <= CB'(PROD_W'(med_q) * PROD_W'(lo_n));
			hi_prod_q <= CB'(PROD_W'(med_q) * PROD_W'(hi_n));
		end
		if (state_q == ST_DONE && out_free) begin
			cost_q <= lo_prod_q - lo_sum_q + hi_sum_q - hi_prod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ws_q         <= CNT_W'(1);
			count_q      <= '0;
			pos_q        <= '0;
			scan_q       <= '0;
			cost_valid_q <= 1'b0;
		end else begin
			if (cost_valid_q && !cost_stall) begin
				cost_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_write) begin
						ws_q    <= cfg_size;
						count_q <= '0;
						pos_q   <= '0;
					end else if (accept) begin
						count_q <= cnt_eff;
						pos_q   <= pos_wrap ? '0 : pos_eff + IDX_W'(1);
						state_q <= (cnt_eff >= ws_q) ? ST_REMOVE : ST_INSERT;
					end
				end
				ST_REMOVE: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= ST_INSERT;
				end
				ST_INSERT: begin
					count_q <= count_q + CNT_W'(1);
					scan_q  <= '0;
					state_q <= ((count_q + CNT_W'(1)) >= ws_q) ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(MAX_WINDOW - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						cost_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/swmc_cell.sv -----
// ----------------------------------------------------------------------------
// swmc_cell: one slot of the sorted window
// Holds one sample; removes, inserts or rotates using only its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module swmc_cell #(
	parameter int SAMPLE_BITS = swmc_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = 9,
	parameter int INDEX       = 0
) (
	input  wire                      clk,
	input  swmc_pkg::cell_op_t       op,
	input  wire  [CNT_W-1:0]         count,
	input  wire  [SAMPLE_BITS-1:0]   operand,
	input  wire  [SAMPLE_BITS-1:0]   left_value,
	input  wire  [SAMPLE_BITS-1:0]   right_value,
	output logic [SAMPLE_BITS-1:0]   value
);

	localparam logic [CNT_W:0] IDX = (CNT_W+1)'(INDEX);

	logic in_range;
	logic at_or_below;
	logic left_le;

	assign in_range    = IDX < {1'b0, count};
	assign at_or_below = IDX <= {1'b0, count};
	assign left_le     = (INDEX == 0) || (left_value <= operand);

	always_ff @(posedge clk) begin
		case (op)
			swmc_pkg::CELL_REMOVE: begin
				if (in_range && value >= operand) begin
					value <= right_value;
				end
			end
			swmc_pkg::CELL_INSERT: begin
				if (!(in_range && value <= operand) && at_or_below) begin
					value <= left_le ? operand : left_value;
				end
			end
			swmc_pkg::CELL_ROTATE: begin
				value <= right_value;
			end
			default: begin
				value <= value;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/swmc_checker.sv -----
// ----------------------------------------------------------------------------
// swmc_checker: port-level checks for sliding_window_median_cost
// Watches the handshakes and the busy behavior seen at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module swmc_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                sample_valid,
	input wire                                sample_stall,
	input wire                                cost_valid,
	input wire                                cost_stall,
	input wire [swmc_pkg::COST_BITS-1:0]      window_cost,
	input wire                                cfg_valid,
	input wire                                cfg_ready
);

	a_cost_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cost_valid && cost_stall |=> cost_valid && $stable(window_cost))
		else $error("stalled result changed");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("sample taken while previous still in work");

	a_cfg_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !$rose(cost_valid))
		else $error("result appeared right after a window size write");

	a_idle_match: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_stall |-> cfg_ready)
		else $error("sample port open while config port closed");

endmodule

bind sliding_window_median_cost swmc_checker u_swmc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_stall(sample_stall),
	.cost_valid(cost_valid),
	.cost_stall(cost_stall),
	.window_cost(window_cost),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

`default_nettype wire
